// ===== sv/flpq_pkg.sv =====
// ----------------------------------------------------------------------------
// flpq_pkg
// Shared types and constants of the four-class priority queue with statistics.
// ----------------------------------------------------------------------------
package flpq_pkg;

    localparam int NUM_CLASSES     = 4;
    localparam int CLASS_W         = 2;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int MIN_PER_HOUR    = 60;

    localparam int OPCODE_W  = 2;
    localparam int ID_W      = 16;
    localparam int ICLASS_W  = 3;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int TIME_W    = 11;
    localparam int ENTRY_W   = ID_W + TIME_W;

    localparam int STATUS_W  = 3;
    localparam int WAIT_W    = 12;
    localparam int LEN_W     = 7;
    localparam int CTR_W     = 32;
    localparam int PEAK_W    = 9;
    localparam int LONG_W    = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ARRIVE = 2'd0,
        OP_SERVE  = 2'd1,
        OP_REPORT = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED  = 3'd0,
        ST_SERVED  = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_IGNORED = 3'd3,
        ST_FULL    = 3'd4,
        ST_REPORT  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

    // Statistics update, applied on the cycle a serve result is committed.
    typedef struct packed {
        logic               serve_en;
        logic [CLASS_W-1:0] class_idx;
        logic               wait_en;
        logic [LONG_W-1:0]  wait_val;
    } stat_upd_t;

endpackage

// ===== sv/flpq_if.sv =====
// ----------------------------------------------------------------------------
// flpq_if
// Command and response channels of the priority queue, valid/ready handshake.
// ----------------------------------------------------------------------------
interface flpq_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [flpq_pkg::OPCODE_W-1:0] opcode;
    logic [flpq_pkg::ID_W-1:0]     item_id;
    logic [flpq_pkg::ICLASS_W-1:0] item_class;
    logic [flpq_pkg::HOUR_W-1:0]   hour;
    logic [flpq_pkg::MINUTE_W-1:0] minute;

    modport source (output valid, opcode, item_id, item_class, hour, minute, input ready);
    modport sink   (input valid, opcode, item_id, item_class, hour, minute, output ready);
endinterface

interface flpq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [flpq_pkg::STATUS_W-1:0]      status;
    logic [flpq_pkg::ID_W-1:0]          served_id;
    logic [flpq_pkg::CLASS_W-1:0]       served_class;
    logic signed [flpq_pkg::WAIT_W-1:0] wait_minutes;
    logic [flpq_pkg::LEN_W-1:0]         length_class0;
    logic [flpq_pkg::LEN_W-1:0]         length_class1;
    logic [flpq_pkg::LEN_W-1:0]         length_class2;
    logic [flpq_pkg::LEN_W-1:0]         length_class3;
    logic [flpq_pkg::CTR_W-1:0]         total_served;
    logic [flpq_pkg::PEAK_W-1:0]        peak_occupancy;
    logic [flpq_pkg::LONG_W-1:0]        longest_wait;
    logic [flpq_pkg::CTR_W-1:0]         class_served_count;

    modport source (output valid, status, served_id, served_class, wait_minutes,
                    length_class0, length_class1, length_class2, length_class3,
                    total_served, peak_occupancy, longest_wait, class_served_count,
                    input ready);
    modport sink   (input valid, status, served_id, served_class, wait_minutes,
                    length_class0, length_class1, length_class2, length_class3,
                    total_served, peak_occupancy, longest_wait, class_served_count,
                    output ready);
endinterface

// ===== sv/flpq_entry_ram.sv =====
// ----------------------------------------------------------------------------
// flpq_entry_ram
// Single-port-write, single-port-read entry memory with registered read data.
// ----------------------------------------------------------------------------
module flpq_entry_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [flpq_pkg::ENTRY_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [flpq_pkg::ENTRY_W-1:0] rd_data
);
    import flpq_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/flpq_stats.sv =====
// ----------------------------------------------------------------------------
// flpq_stats
// Per-class and total served counters (saturating) and the longest wait.
// ----------------------------------------------------------------------------
module flpq_stats (
    input  logic                       clk,
    input  logic                       rst_n,
    input  flpq_pkg::stat_upd_t        upd,
    output logic [flpq_pkg::CTR_W-1:0]  total_next,
    output logic [flpq_pkg::LONG_W-1:0] longest_next,
    output logic [flpq_pkg::CTR_W-1:0]  class_count
);
    import flpq_pkg::*;

    logic [CTR_W-1:0]  served_reg [NUM_CLASSES];
    logic [CTR_W-1:0]  total_reg;
    logic [LONG_W-1:0] longest_reg;
    logic [CTR_W-1:0]  class_next;

    function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
        sat_inc = (v == '1) ? v : v + CTR_W'(1);
    endfunction

    always_comb
    begin
        class_count  = served_reg[upd.class_idx];
        class_next   = sat_inc(class_count);
        total_next   = upd.serve_en ? sat_inc(total_reg) : total_reg;
        longest_next = (upd.serve_en && upd.wait_en && (upd.wait_val > longest_reg))
                       ? upd.wait_val : longest_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                served_reg[c] <= '0;
            end
            total_reg   <= '0;
            longest_reg <= '0;
        end
        else
        begin
            if (upd.serve_en)
            begin
                served_reg[upd.class_idx] <= class_next;
            end
            total_reg   <= total_next;
            longest_reg <= longest_next;
        end
    end

endmodule

// ===== sv/four_level_priority_queue_stats_core.sv =====
// ----------------------------------------------------------------------------
// four_level_priority_queue_stats_core
// Four strict-priority FIFO queues in one entry memory, with service statistics.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  cmd     | sink      | opcode, item_id, item_class, hour, minute
//  rsp     | source    | status, served entry, wait, queue lengths, statistics
//
//  An item is registered in one cycle and executed in the next. Arrive, report
//  and empty-serve transactions commit from the execute state; a serve with a
//  waiting entry first reads the entry memory and commits from the read state.
//  The response register holds a result until it is taken; a new command is
//  accepted meanwhile and waits in its execute or read state for the register to free.
//  Reset clears all queues and counters; the entry memory needs no clearing.
// ----------------------------------------------------------------------------
module four_level_priority_queue_stats_core #(
    parameter int QUEUE_DEPTH = flpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    flpq_cmd_if.sink          cmd,
    flpq_rsp_if.source        rsp
);
    import flpq_pkg::*;

    localparam int MEM_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W     = $clog2(MEM_DEPTH + 1);

    state_t state_reg, state_next;

    logic [OPCODE_W-1:0] op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [ICLASS_W-1:0] cls_reg;
    logic [TIME_W-1:0]   now_reg;

    logic [PTR_W-1:0] head_reg  [NUM_CLASSES];
    logic [PTR_W-1:0] head_next [NUM_CLASSES];
    logic [CNT_W-1:0] count_reg [NUM_CLASSES];
    logic [CNT_W-1:0] count_next[NUM_CLASSES];
    logic [OCC_W-1:0] peak_reg, peak_next;

    logic                rsp_valid_reg;
    status_t             rsp_status_reg, rsp_status_next;
    logic [ID_W-1:0]     rsp_id_reg, rsp_id_next;
    logic [CLASS_W-1:0]  rsp_class_reg, rsp_class_next;
    logic [WAIT_W-1:0]   rsp_wait_reg, rsp_wait_next;
    logic [LEN_W-1:0]    rsp_len_reg [NUM_CLASSES];
    logic [CTR_W-1:0]    rsp_total_reg;
    logic [PEAK_W-1:0]   rsp_peak_reg;
    logic [LONG_W-1:0]   rsp_long_reg;
    logic [CTR_W-1:0]    rsp_rep_reg, rsp_rep_next;

    logic [CLASS_W-1:0]  pick_class, sel_class;
    logic                any_waiting;
    logic                cls_ok, is_full;
    logic                rsp_free, commit, rd_en, wr_en;
    logic [PTR_W:0]      pos_sum;
    logic [PTR_W-1:0]    pos;
    logic [ADDR_W-1:0]   wr_addr, rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic [TIME_W-1:0]   arr_time;
    logic [OCC_W-1:0]    occ_next, occ_now;
    logic [TIME_W-1:0]   cmd_now;

    stat_upd_t           upd;
    logic [CTR_W-1:0]    total_next;
    logic [LONG_W-1:0]   longest_next;
    logic [CTR_W-1:0]    class_count;

    // Highest-priority non-empty class; class 0 wins.
    always_comb
    begin
        pick_class  = '0;
        any_waiting = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (count_reg[c] != '0)
            begin
                pick_class  = CLASS_W'(c);
                any_waiting = 1'b1;
            end
        end
    end

    assign cmd_now   = TIME_W'(cmd.hour) * TIME_W'(MIN_PER_HOUR) + TIME_W'(cmd.minute);
    assign sel_class = (op_reg == OP_SERVE) ? pick_class : cls_reg[CLASS_W-1:0];
    assign cls_ok    = (cls_reg < ICLASS_W'(NUM_CLASSES));
    assign is_full   = (count_reg[sel_class] == CNT_W'(QUEUE_DEPTH));

    // Tail position wraps with one compare-subtract: head stays below depth and count never exceeds it.
    assign pos_sum = (PTR_W+1)'(head_reg[sel_class]) + (PTR_W+1)'(count_reg[sel_class]);
    assign pos     = (pos_sum >= (PTR_W+1)'(QUEUE_DEPTH))
                     ? PTR_W'(pos_sum - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(pos_sum);
    assign wr_addr = ADDR_W'(sel_class) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
    assign rd_addr = ADDR_W'(sel_class) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_reg[sel_class]);

    assign rsp_free = !rsp_valid_reg || rsp.ready;
    assign arr_time = rd_data[TIME_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        commit          = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        rsp_status_next = ST_IGNORED;
        rsp_id_next     = '0;
        rsp_class_next  = '0;
        rsp_wait_next   = '0;
        rsp_rep_next    = '0;
        upd             = '0;
        upd.class_idx   = sel_class;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            head_next[c]  = head_reg[c];
            count_next[c] = count_reg[c];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if ((op_reg == OP_SERVE) && any_waiting)
                begin
                    rd_en      = 1'b1;
                    state_next = S_READ;
                end
                else if (rsp_free)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_ARRIVE:
                        begin
                            if (!cls_ok)
                            begin
                                rsp_status_next = ST_IGNORED;
                            end
                            else if (is_full)
                            begin
                                rsp_status_next = ST_FULL;
                            end
                            else
                            begin
                                rsp_status_next       = ST_QUEUED;
                                wr_en                 = 1'b1;
                                count_next[sel_class] = count_reg[sel_class] + CNT_W'(1);
                            end
                        end
                        OP_SERVE:
                        begin
                            rsp_status_next = ST_EMPTY;
                        end
                        OP_REPORT:
                        begin
                            rsp_status_next = ST_REPORT;
                            rsp_rep_next    = cls_ok ? class_count : '0;
                        end
                        default:
                        begin
                            rsp_status_next = ST_IGNORED;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (rsp_free)
                begin
                    commit          = 1'b1;
                    state_next      = S_IDLE;
                    rsp_status_next = ST_SERVED;
                    rsp_id_next     = rd_data[ENTRY_W-1:TIME_W];
                    rsp_class_next  = pick_class;
                    rsp_wait_next   = {1'b0, now_reg} - {1'b0, arr_time};
                    upd.serve_en    = 1'b1;
                    upd.wait_en     = (now_reg >= arr_time);
                    upd.wait_val    = now_reg - arr_time;
                    head_next[pick_class]  = (head_reg[pick_class] == PTR_W'(QUEUE_DEPTH - 1))
                                             ? '0 : head_reg[pick_class] + PTR_W'(1);
                    count_next[pick_class] = count_reg[pick_class] - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        occ_next = '0;
        occ_now  = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            occ_next = occ_next + OCC_W'(count_next[c]);
            occ_now  = occ_now + OCC_W'(count_reg[c]);
        end
        peak_next = peak_reg;
        if (commit && (op_reg == OP_ARRIVE) && (occ_next > peak_reg))
        begin
            peak_next = occ_next;
        end
    end

    flpq_entry_ram #(
        .DEPTH (MEM_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_entry_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data({id_reg, now_reg}),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    flpq_stats u_stats (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (upd),
        .total_next  (total_next),
        .longest_next(longest_next),
        .class_count (class_count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            peak_reg      <= '0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c]  <= '0;
                count_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            peak_reg  <= peak_next;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c]  <= head_next[c];
                count_reg[c] <= count_next[c];
            end
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            op_reg  <= cmd.opcode;
            id_reg  <= cmd.item_id;
            cls_reg <= cmd.item_class;
            now_reg <= cmd_now;
        end
        if (commit)
        begin
            rsp_status_reg <= rsp_status_next;
            rsp_id_reg     <= rsp_id_next;
            rsp_class_reg  <= rsp_class_next;
            rsp_wait_reg   <= rsp_wait_next;
            rsp_total_reg  <= total_next;
            rsp_peak_reg   <= PEAK_W'(peak_next);
            rsp_long_reg   <= longest_next;
            rsp_rep_reg    <= rsp_rep_next;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                rsp_len_reg[c] <= LEN_W'(count_next[c]);
            end
        end
    end

    assign cmd.ready              = (state_reg == S_IDLE);
    assign rsp.valid              = rsp_valid_reg;
    assign rsp.status             = rsp_status_reg;
    assign rsp.served_id          = rsp_id_reg;
    assign rsp.served_class       = rsp_class_reg;
    assign rsp.wait_minutes       = $signed(rsp_wait_reg);
    assign rsp.length_class0      = rsp_len_reg[0];
    assign rsp.length_class1      = rsp_len_reg[1];
    assign rsp.length_class2      = rsp_len_reg[2];
    assign rsp.length_class3      = rsp_len_reg[3];
    assign rsp.total_served       = rsp_total_reg;
    assign rsp.peak_occupancy     = rsp_peak_reg;
    assign rsp.longest_wait       = rsp_long_reg;
    assign rsp.class_served_count = rsp_rep_reg;

    // A memory read is only pending for a class that still holds an entry.
    a_read_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> any_waiting)
        else $error("serve read pending with all queues empty");

    // Every accepted command moves straight to execution.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> (state_reg == S_EXEC))
        else $error("accepted command did not enter execution");

    // No queue ever holds more than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[0] <= CNT_W'(QUEUE_DEPTH)) && (count_reg[1] <= CNT_W'(QUEUE_DEPTH)) &&
        (count_reg[2] <= CNT_W'(QUEUE_DEPTH)) && (count_reg[3] <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue count exceeds depth");

    // Occupancy only grows on arrivals, so the peak always covers it.
    a_peak_covers: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= occ_now)
        else $error("peak occupancy below current occupancy");

    // The response register is loaded only when it is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!rsp_valid_reg || rsp.ready))
        else $error("result overwritten before it was taken");

endmodule
